@@ rtl/sdae_pkg.sv @@
package sdae_pkg;

    localparam int MAX_DIGITS = 10;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    localparam int VAL_W   = 32;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;

    // floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for every 32-bit x
    localparam logic [VAL_W-1:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int               RECIP_SHIFT = 35;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;

    // queue between front and back: two entries
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic             neg;
        logic [VAL_W-1:0] mag;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SIGN,
        ST_DIGIT
    } t_back_state;

endpackage

@@ rtl/sdae_if.sv @@
interface sdae_in_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] value_hundredths;

    modport source (output valid, output value_hundredths, input ready);
    modport sink   (input valid, input value_hundredths, output ready);
endinterface

interface sdae_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

@@ rtl/signed_decimal_ascii_emitter_unit.sv @@
// Signed decimal text emitter: each input word is a signed 32-bit count of
// hundredths; the block sends its decimal ASCII text, most significant
// character first, one character per output word, with last_char set on the
// final one. Negative values start with '-', zero gives "0", and the most
// negative value prints in full. No decimal point is inserted. The back end
// pops a number from the queue only when idle, splits it into digits (one
// 32x32 reciprocal multiply and one remainder step per digit, a shared unit)
// and then sends its characters one at a time as the sink takes each word.
// The front stage and a two-entry queue keep taking input words while the
// back end works.
module signed_decimal_ascii_emitter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdae_in_if.sink     i_in,
    sdae_out_if.source  o_out
);

    logic           w_push_valid;
    logic           w_push_ready;
    sdae_pkg::t_job w_push_job;
    logic           w_pop_valid;
    logic           w_pop_ready;
    sdae_pkg::t_job w_pop_job;

    // front: take the word, split off sign and unsigned magnitude
    sdae_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (w_push_valid),
        .o_push_job   (w_push_job),
        .i_push_ready (w_push_ready)
    );

    // hold pending numbers so either side can stall on its own
    sdae_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_job   (w_push_job),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_job    (w_pop_job),
        .i_pop_ready  (w_pop_ready)
    );

    // back: split into digits, then emit sign and digits from the top
    sdae_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .i_pop_job   (w_pop_job),
        .o_pop_ready (w_pop_ready),
        .o_out       (o_out)
    );

endmodule

@@ rtl/sdae_front.sv @@
module sdae_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sdae_in_if.sink              i_in,
    output logic                 o_push_valid,
    output sdae_pkg::t_job       o_push_job,
    input  logic                 i_push_ready
);

    logic           r_valid;
    sdae_pkg::t_job r_job;
    logic [sdae_pkg::VAL_W-1:0] w_raw;

    // hold the classified word until the queue takes it
    assign i_in.ready   = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_job   = r_job;
    assign w_raw        = i_in.value_hundredths;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // unsigned magnitude covers the most negative value
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_job.neg <= w_raw[sdae_pkg::VAL_W-1];
            r_job.mag <= w_raw[sdae_pkg::VAL_W-1] ? (~w_raw + 32'd1) : w_raw;
        end
    end

endmodule

@@ rtl/sdae_queue.sv @@
module sdae_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  sdae_pkg::t_job i_push_job,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output sdae_pkg::t_job o_pop_job,
    input  logic           i_pop_ready
);

    sdae_pkg::t_job                r_slot [sdae_pkg::QDEPTH];
    logic [sdae_pkg::QPTR_W-1:0]   r_wr;
    logic [sdae_pkg::QPTR_W-1:0]   r_rd;
    logic [sdae_pkg::QCNT_W-1:0]   r_cnt;
    logic                          w_push;
    logic                          w_pop;

    assign o_push_ready = (r_cnt != sdae_pkg::QCNT_W'(sdae_pkg::QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_job    = r_slot[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_slot[r_wr] <= i_push_job;
    end

endmodule

@@ rtl/sdae_back.sv @@
module sdae_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    input  sdae_pkg::t_job i_pop_job,
    output logic           o_pop_ready,
    sdae_out_if.source     o_out
);

    sdae_pkg::t_back_state r_state, n_state;

    logic [sdae_pkg::VAL_W-1:0]   r_mag,  n_mag;
    logic                         r_neg,  n_neg;
    logic [sdae_pkg::CNT_W-1:0]   r_cnt,  n_cnt;
    logic [sdae_pkg::CNT_W-1:0]   r_emit, n_emit;
    logic [sdae_pkg::PROD_W-1:0]  r_prod;
    logic                         r_out_valid, n_out_valid;
    logic [sdae_pkg::CHAR_W-1:0]  r_out_char,  n_out_char;
    logic                         r_out_last,  n_out_last;

    logic [sdae_pkg::DIGIT_W-1:0] r_store [sdae_pkg::MAX_DIGITS];

    logic [sdae_pkg::VAL_W-1:0]   w_quot;
    logic [sdae_pkg::VAL_W-1:0]   w_rem_full;
    logic [sdae_pkg::DIGIT_W-1:0] w_rem;
    logic                         w_store_we;
    logic [sdae_pkg::CNT_W-1:0]   w_rd_full;
    logic [sdae_pkg::DIGIT_W-1:0] w_rd_digit;
    logic                         w_out_free;

    // quotient from the registered product, remainder by shift-add
    assign w_quot     = sdae_pkg::VAL_W'(r_prod >> sdae_pkg::RECIP_SHIFT);
    assign w_rem_full = r_mag - ((w_quot << 3) + (w_quot << 1));
    assign w_rem      = w_rem_full[sdae_pkg::DIGIT_W-1:0];

    assign w_rd_full  = r_emit - 1'b1;
    assign w_rd_digit = r_store[w_rd_full[sdae_pkg::IDX_W-1:0]];
    assign w_out_free = !r_out_valid || o_out.ready;

    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_out_char;
    assign o_out.last_char = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_emit      = r_emit;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_pop_ready = 1'b0;
        w_store_we  = 1'b0;
        unique case (r_state)
            sdae_pkg::ST_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    n_mag   = i_pop_job.mag;
                    n_neg   = i_pop_job.neg;
                    n_cnt   = '0;
                    n_state = sdae_pkg::ST_MUL;
                end
            end
            sdae_pkg::ST_MUL: begin
                n_state = sdae_pkg::ST_DIV;
            end
            sdae_pkg::ST_DIV: begin
                // drop digits beyond the store
                if (r_cnt < sdae_pkg::CNT_W'(sdae_pkg::MAX_DIGITS)) begin
                    w_store_we = 1'b1;
                    n_cnt      = r_cnt + 1'b1;
                end
                n_mag = w_quot;
                if (w_quot == '0) begin
                    n_emit  = n_cnt;
                    n_state = r_neg ? sdae_pkg::ST_SIGN : sdae_pkg::ST_DIGIT;
                end else begin
                    n_state = sdae_pkg::ST_MUL;
                end
            end
            sdae_pkg::ST_SIGN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = sdae_pkg::CH_MINUS;
                    n_out_last  = (r_cnt == '0);
                    n_state     = sdae_pkg::ST_DIGIT;
                end
            end
            sdae_pkg::ST_DIGIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = sdae_pkg::CH_ZERO + sdae_pkg::CHAR_W'(w_rd_digit);
                    n_out_last  = (r_emit == sdae_pkg::CNT_W'(1));
                    n_emit      = r_emit - 1'b1;
                    if (r_emit == sdae_pkg::CNT_W'(1)) n_state = sdae_pkg::ST_IDLE;
                end
            end
            default: n_state = sdae_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdae_pkg::ST_IDLE;
        end else begin
            r_state     <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_emit      <= '0;
            r_neg       <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_emit      <= n_emit;
            r_neg       <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_prod     <= sdae_pkg::PROD_W'(r_mag) * sdae_pkg::PROD_W'(sdae_pkg::RECIP10);
        if (w_store_we) r_store[r_cnt[sdae_pkg::IDX_W-1:0]] <= w_rem;
    end

endmodule

@@ rtl/sdae_checker.sv @@
module sdae_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_last
);

    logic r_mid;
    logic r_prev_minus;
    logic w_take;

    assign w_take = i_out_valid && i_out_ready;

    // track position inside the current number's text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid        <= 1'b0;
            r_prev_minus <= 1'b0;
        end else if (w_take) begin
            r_mid        <= !i_out_last;
            r_prev_minus <= (i_out_char == sdae_pkg::CH_MINUS);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_char) && $stable(i_out_last))
        else $error("output word changed while stalled");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_char == sdae_pkg::CH_MINUS |-> !i_out_last)
        else $error("sign flagged as last character");

    a_minus_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_mid |-> i_out_char != sdae_pkg::CH_MINUS)
        else $error("sign inside a number");

    a_no_lead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (!r_mid || r_prev_minus) && i_out_char == sdae_pkg::CH_ZERO
            |-> i_out_last && !r_prev_minus)
        else $error("leading zero emitted");

endmodule

bind signed_decimal_ascii_emitter_unit sdae_checker u_sdae_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.char_code),
    .i_out_last  (o_out.last_char)
);
